[design/hfg_pkg.sv]
// Package with shared constants, types and the weight table for the half-to-full grid interpolator.
package hfg_pkg;

    localparam int NS_MAX      = 64;
    localparam int POINTS_MAX  = 1024;
    localparam int VALUE_BITS  = 32;
    localparam int GRID_DEPTH  = (NS_MAX - 1) * POINTS_MAX;
    localparam int ADDR_W      = $clog2(GRID_DEPTH);
    localparam int ACC_W       = VALUE_BITS + 8;
    localparam int WEIGHT_W    = 7;
    localparam int NS_W        = 7;
    localparam int PPS_W       = 11;
    localparam int SURF_W      = 6;
    localparam int POINT_W     = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_SURF = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PPS      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOUR     = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_ADDR,
        STAT_CFG,
        STAT_SAT
    } status_t;

    typedef enum logic {
        FUNC_LOAD,
        FUNC_COMPUTE
    } func_t;

    typedef struct packed {
        func_t                        func;
        logic [SURF_W-1:0]            surface;
        logic [POINT_W-1:0]           point;
        logic signed [VALUE_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        status_t                      status;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WRITE,
        S_READ,
        S_ROUND,
        S_OUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic acc_en;
    } mac_ctrl_t;

    // Lagrange weights in sixteenths, by stencil offset t and tap k.
    function automatic logic signed [WEIGHT_W-1:0] weight(
        input logic       four,
        input logic [2:0] t,
        input logic [1:0] k
    );
        logic signed [WEIGHT_W-1:0] w;
        w = '0;
        if (four) begin
            case ({t, k})
                5'b000_00: w = 7'sd35;
                5'b000_01: w = -7'sd35;
                5'b000_10: w = 7'sd21;
                5'b000_11: w = -7'sd5;
                5'b001_00: w = 7'sd5;
                5'b001_01: w = 7'sd15;
                5'b001_10: w = -7'sd5;
                5'b001_11: w = 7'sd1;
                5'b010_00: w = -7'sd1;
                5'b010_01: w = 7'sd9;
                5'b010_10: w = 7'sd9;
                5'b010_11: w = -7'sd1;
                5'b011_00: w = 7'sd1;
                5'b011_01: w = -7'sd5;
                5'b011_10: w = 7'sd15;
                5'b011_11: w = 7'sd5;
                5'b100_00: w = -7'sd5;
                5'b100_01: w = 7'sd21;
                5'b100_10: w = -7'sd35;
                5'b100_11: w = 7'sd35;
                default:   w = '0;
            endcase
        end else begin
            case ({t, k[0]})
                4'b000_0: w = 7'sd24;
                4'b000_1: w = -7'sd8;
                4'b001_0: w = 7'sd8;
                4'b001_1: w = 7'sd8;
                4'b010_0: w = -7'sd8;
                4'b010_1: w = 7'sd24;
                default:  w = '0;
            endcase
        end
        return w;
    endfunction

endpackage

[design/hfg_ram.sv]
// Generic single-port RAM with registered read data.
module hfg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[design/hfg_mac.sv]
// Shared multiply-accumulate unit with rounding shift and saturation.
module hfg_mac (
    input  logic                                clk,
    input  hfg_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [hfg_pkg::WEIGHT_W-1:0] weight,
    input  logic signed [hfg_pkg::VALUE_BITS-1:0] sample,
    output logic signed [hfg_pkg::VALUE_BITS-1:0] value,
    output logic                                sat
);

    localparam logic signed [hfg_pkg::ACC_W-1:0] VMAX =
        hfg_pkg::ACC_W'((longint'(1) <<< (hfg_pkg::VALUE_BITS - 1)) - 1);
    localparam logic signed [hfg_pkg::ACC_W-1:0] VMIN = -VMAX - 1;
    localparam logic signed [hfg_pkg::ACC_W-1:0] ROUND_HALF = hfg_pkg::ACC_W'(8);

    logic signed [hfg_pkg::ACC_W-1:0]                         acc_reg;
    logic signed [hfg_pkg::ACC_W-1:0]                         acc_next;
    logic signed [hfg_pkg::WEIGHT_W+hfg_pkg::VALUE_BITS-1:0] prod;
    logic signed [hfg_pkg::ACC_W-1:0]                         rounded;
    logic signed [hfg_pkg::ACC_W-1:0]                         quot;

    assign prod = weight * sample;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end else if (ctrl.acc_en)
        begin
            acc_next = acc_reg + hfg_pkg::ACC_W'(prod);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Adding half an LSB and shifting arithmetically gives round-half-up.
    assign rounded = acc_reg + ROUND_HALF;
    assign quot    = rounded >>> 4;

    always_comb
    begin
        sat   = 1'b0;
        value = quot[hfg_pkg::VALUE_BITS-1:0];
        if (quot > VMAX)
        begin
            sat   = 1'b1;
            value = VMAX[hfg_pkg::VALUE_BITS-1:0];
        end else if (quot < VMIN)
        begin
            sat   = 1'b1;
            value = VMIN[hfg_pkg::VALUE_BITS-1:0];
        end
    end

endmodule

[design/half_to_full_grid_lagrange_interp.sv]
// Top level: sequencer, configuration registers and half-grid store of the interpolator.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------
//  in       | input     | in_valid / in_stall  | in_item  (func, surface, point, sample)
//  out      | output    | out_valid / out_stall| out_item (value, status)
//  cfg      | input     | cfg_we               | cfg_index, cfg_data
//
// One item is in flight at a time. A load goes through decode and write to its result,
// an error from decode straight to its result, and a compute through decode, read and
// round: the single memory port delivers one stencil sample per cycle into the shared
// multiply-accumulate unit, and the round state rounds; idle follows the taken result beat.
// Reset idles the sequencer and presets the configuration registers; the store is kept.
// A stalled result holds in the output register and no new item is taken until it leaves.
module half_to_full_grid_lagrange_interp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  hfg_pkg::in_item_t                  in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output hfg_pkg::out_item_t                 out_item,
    input  logic                               cfg_we,
    input  logic [hfg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hfg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    hfg_pkg::state_t    state_reg, state_next;
    hfg_pkg::in_item_t  item_reg, item_next;
    hfg_pkg::out_item_t res_reg, res_next;
    hfg_pkg::mac_ctrl_t mac_ctrl;

    logic [hfg_pkg::NS_W-1:0]   ns_reg;
    logic [hfg_pkg::PPS_W-1:0]  pps_reg;
    logic                       four_reg;
    logic [hfg_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [2:0]                 cnt_reg, cnt_next;
    logic [2:0]                 t_reg, t_next;

    logic [2:0]                 width;
    logic                       cfg_ok;
    logic [hfg_pkg::NS_W-1:0]   halves;
    logic                       load_bad;
    logic                       comp_bad;
    logic signed [7:0]          start_pre;
    logic signed [7:0]          start_max;
    logic [hfg_pkg::SURF_W-1:0] start_c;
    logic [hfg_pkg::SURF_W-1:0] base_surf;
    logic [hfg_pkg::SURF_W+hfg_pkg::PPS_W-1:0] prod;
    logic [hfg_pkg::ADDR_W-1:0] addr_c;
    logic                       accept;
    logic                       read_done;

    logic                                  ram_we;
    logic [hfg_pkg::VALUE_BITS-1:0]        ram_rdata;
    logic signed [hfg_pkg::WEIGHT_W-1:0]   mac_weight;
    logic signed [hfg_pkg::VALUE_BITS-1:0] mac_value;
    logic                                  mac_sat;

    assign accept = in_valid && !in_stall;
    assign width  = four_reg ? 3'd4 : 3'd2;
    assign halves = ns_reg - 7'd1;

    assign cfg_ok = (ns_reg >= 7'd3) && (ns_reg <= hfg_pkg::NS_W'(hfg_pkg::NS_MAX))
                 && (pps_reg >= 11'd1) && (pps_reg <= hfg_pkg::PPS_W'(hfg_pkg::POINTS_MAX))
                 && (halves >= {4'b0, width});

    assign load_bad = ({1'b0, item_reg.surface} >= halves)
                   || ({1'b0, item_reg.point} >= pps_reg);
    assign comp_bad = ({1'b0, item_reg.surface} >= ns_reg)
                   || ({1'b0, item_reg.point} >= pps_reg);

    // The stencil is centered on the target surface, then clamped into the half grid.
    assign start_pre = $signed({2'b0, item_reg.surface}) - (four_reg ? 8'sd2 : 8'sd1);
    assign start_max = $signed({1'b0, halves}) - $signed({5'b0, width});

    always_comb
    begin
        start_c = start_pre[hfg_pkg::SURF_W-1:0];
        if (start_pre < 8'sd0)
        begin
            start_c = '0;
        end else if (start_pre > start_max)
        begin
            start_c = start_max[hfg_pkg::SURF_W-1:0];
        end
    end

    assign base_surf = (item_reg.func == hfg_pkg::FUNC_LOAD) ? item_reg.surface : start_c;
    assign prod      = {{hfg_pkg::PPS_W{1'b0}}, base_surf} * {{hfg_pkg::SURF_W{1'b0}}, pps_reg};
    assign addr_c    = hfg_pkg::ADDR_W'(prod + (hfg_pkg::SURF_W + hfg_pkg::PPS_W)'(item_reg.point));

    assign read_done  = (cnt_reg == width);
    assign mac_weight = hfg_pkg::weight(four_reg, t_reg, 2'(cnt_reg - 3'd1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hfg_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = hfg_pkg::S_DECODE;
                end
            end
            hfg_pkg::S_DECODE:
            begin
                if (!cfg_ok)
                begin
                    state_next = hfg_pkg::S_OUT;
                end else if (item_reg.func == hfg_pkg::FUNC_LOAD)
                begin
                    state_next = load_bad ? hfg_pkg::S_OUT : hfg_pkg::S_WRITE;
                end else
                begin
                    state_next = comp_bad ? hfg_pkg::S_OUT : hfg_pkg::S_READ;
                end
            end
            hfg_pkg::S_WRITE: state_next = hfg_pkg::S_OUT;
            hfg_pkg::S_READ:
            begin
                if (read_done)
                begin
                    state_next = hfg_pkg::S_ROUND;
                end
            end
            hfg_pkg::S_ROUND: state_next = hfg_pkg::S_OUT;
            hfg_pkg::S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = hfg_pkg::S_IDLE;
                end
            end
            default: state_next = hfg_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_stall        = 1'b1;
        out_valid       = 1'b0;
        ram_we          = 1'b0;
        mac_ctrl.clear  = 1'b0;
        mac_ctrl.acc_en = 1'b0;
        case (state_reg)
            hfg_pkg::S_IDLE:   in_stall = 1'b0;
            hfg_pkg::S_DECODE: mac_ctrl.clear = 1'b1;
            hfg_pkg::S_WRITE:  ram_we = 1'b1;
            hfg_pkg::S_READ:   mac_ctrl.acc_en = (cnt_reg != 3'd0);
            hfg_pkg::S_ROUND:  in_stall = 1'b1;
            hfg_pkg::S_OUT:    out_valid = 1'b1;
            default:           in_stall = 1'b1;
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        item_next = item_reg;
        res_next  = res_reg;
        addr_next = addr_reg;
        cnt_next  = cnt_reg;
        t_next    = t_reg;
        case (state_reg)
            hfg_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_item;
                end
            end
            hfg_pkg::S_DECODE:
            begin
                addr_next    = addr_c;
                cnt_next     = 3'd0;
                t_next       = 3'(item_reg.surface - start_c);
                res_next.value = '0;
                if (!cfg_ok)
                begin
                    res_next.status = hfg_pkg::STAT_CFG;
                end else if (item_reg.func == hfg_pkg::FUNC_LOAD)
                begin
                    res_next.status = load_bad ? hfg_pkg::STAT_ADDR : hfg_pkg::STAT_OK;
                end else
                begin
                    res_next.status = comp_bad ? hfg_pkg::STAT_ADDR : hfg_pkg::STAT_OK;
                end
            end
            hfg_pkg::S_READ:
            begin
                // The address for tap k goes out while tap k-1 enters the accumulator.
                cnt_next  = cnt_reg + 3'd1;
                addr_next = addr_reg + hfg_pkg::ADDR_W'(pps_reg);
            end
            hfg_pkg::S_ROUND:
            begin
                res_next.value  = mac_value;
                res_next.status = mac_sat ? hfg_pkg::STAT_SAT : hfg_pkg::STAT_OK;
            end
            default:
            begin
                item_next = item_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hfg_pkg::S_IDLE;
            ns_reg    <= 7'd5;
            pps_reg   <= 11'd1;
            four_reg  <= 1'b1;
        end else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    hfg_pkg::CFG_NUM_SURF: ns_reg   <= cfg_data[hfg_pkg::NS_W-1:0];
                    hfg_pkg::CFG_PPS:      pps_reg  <= cfg_data[hfg_pkg::PPS_W-1:0];
                    hfg_pkg::CFG_FOUR:     four_reg <= cfg_data[0];
                    default:               four_reg <= four_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        addr_reg <= addr_next;
        cnt_reg  <= cnt_next;
        t_reg    <= t_next;
    end

    assign out_item = res_reg;

    hfg_ram #(
        .WIDTH (hfg_pkg::VALUE_BITS),
        .DEPTH (hfg_pkg::GRID_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr_reg),
        .wdata (item_reg.sample),
        .rdata (ram_rdata)
    );

    hfg_mac u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .weight (mac_weight),
        .sample ($signed(ram_rdata)),
        .value  (mac_value),
        .sat    (mac_sat)
    );

    // A pending result beat blocks new input beats.
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while a result beat is pending");

    // Error results always carry a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == hfg_pkg::STAT_ADDR
                      || out_item.status == hfg_pkg::STAT_CFG)
        |-> out_item.value == '0)
        else $error("error result with nonzero value");

    // The tap counter never runs past the stencil width.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hfg_pkg::S_READ |-> cnt_reg <= width)
        else $error("tap counter overran the stencil");

    // The store is written only for a load that passed its checks.
    a_write_load: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> item_reg.func == hfg_pkg::FUNC_LOAD && $past(cfg_ok) && !$past(load_bad))
        else $error("store written outside a valid load");

endmodule

[sim/hfg_checker.sv]
// Checker for the half-to-full grid interpolator: predicts every result beat and compares it.
module hfg_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  hfg_pkg::in_item_t               in_item,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  hfg_pkg::out_item_t              out_item,
    input  logic                            cfg_we,
    input  logic [hfg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hfg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              pending
);

    localparam longint Q_HI = (64'sd1 <<< (hfg_pkg::VALUE_BITS - 1)) - 1;
    localparam longint Q_LO = -(64'sd1 <<< (hfg_pkg::VALUE_BITS - 1));

    int ns_cfg;
    int pps_cfg;
    int four_cfg;
    int err_cnt;
    logic signed [hfg_pkg::VALUE_BITS-1:0] grid_copy [int];
    hfg_pkg::out_item_t predicted [$];

    // Lagrange weights in sixteenths for nodes at half-integer positions.
    function automatic int tap_weight(input int width, input int t, input int k);
        if (width == 4)
        begin
            case (t * 4 + k)
                0:  return 35;
                1:  return -35;
                2:  return 21;
                3:  return -5;
                4:  return 5;
                5:  return 15;
                6:  return -5;
                7:  return 1;
                8:  return -1;
                9:  return 9;
                10: return 9;
                11: return -1;
                12: return 1;
                13: return -5;
                14: return 15;
                15: return 5;
                16: return -5;
                17: return 21;
                18: return -35;
                19: return 35;
                default: return 0;
            endcase
        end
        case (t * 2 + k)
            0: return 24;
            1: return -8;
            2: return 8;
            3: return 8;
            4: return -8;
            5: return 24;
            default: return 0;
        endcase
    endfunction

    function automatic bit setting_usable();
        int width;
        width = four_cfg ? 4 : 2;
        if (ns_cfg < 3 || ns_cfg > hfg_pkg::NS_MAX) return 1'b0;
        if (pps_cfg < 1 || pps_cfg > hfg_pkg::POINTS_MAX) return 1'b0;
        return (ns_cfg - 1 >= width);
    endfunction

    task automatic interpolate_item(input hfg_pkg::in_item_t it);
        hfg_pkg::out_item_t r;
        int s;
        int p;
        int width;
        int start;
        int t;
        int idx;
        longint acc;
        longint q;
        logic signed [hfg_pkg::VALUE_BITS-1:0] smp;
        r.value = '0;
        r.status = hfg_pkg::STAT_OK;
        s = int'(it.surface);
        p = int'(it.point);
        if (!setting_usable())
        begin
            r.status = hfg_pkg::STAT_CFG;
        end else if (it.func == hfg_pkg::FUNC_LOAD)
        begin
            if (s >= ns_cfg - 1 || p >= pps_cfg)
                r.status = hfg_pkg::STAT_ADDR;
            else
                grid_copy[s * pps_cfg + p] = it.sample;
        end else if (s >= ns_cfg || p >= pps_cfg)
        begin
            r.status = hfg_pkg::STAT_ADDR;
        end else
        begin
            width = four_cfg ? 4 : 2;
            start = s - width / 2;
            if (start < 0)
                start = 0;
            if (start > ns_cfg - 1 - width)
                start = ns_cfg - 1 - width;
            t = s - start;
            acc = '0;
            for (int k = 0; k < width; k++)
            begin
                idx = (start + k) * pps_cfg + p;
                smp = grid_copy.exists(idx) ? grid_copy[idx] : '0;
                acc += longint'(tap_weight(width, t, k)) * longint'(smp);
            end
            // Rounding to nearest, ties upward: add half an LSB, then floor.
            q = (acc + 64'sd8) >>> 4;
            if (q > Q_HI)
            begin
                q = Q_HI;
                r.status = hfg_pkg::STAT_SAT;
            end else if (q < Q_LO)
            begin
                q = Q_LO;
                r.status = hfg_pkg::STAT_SAT;
            end
            r.value = q[hfg_pkg::VALUE_BITS-1:0];
        end
        predicted.push_back(r);
    endtask

    task automatic check_result(input hfg_pkg::out_item_t got);
        hfg_pkg::out_item_t want;
        if (predicted.size() == 0)
        begin
            err_cnt++;
            $display("%0t: result beat with none expected, value %0d status %0d",
                     $time, got.value, got.status);
        end else
        begin
            want = predicted.pop_front();
            if (got.value !== want.value)
            begin
                err_cnt++;
                $display("%0t: value mismatch, expected %0d, got %0d",
                         $time, want.value, got.value);
            end
            if (got.status !== want.status)
            begin
                err_cnt++;
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, got.status);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_cfg = 5;
            pps_cfg = 1;
            four_cfg = 1;
            err_cnt = 0;
            predicted.delete();
            fail_count <= 0;
            pending <= 0;
        end else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    hfg_pkg::CFG_NUM_SURF: ns_cfg = int'(cfg_data[hfg_pkg::NS_W-1:0]);
                    hfg_pkg::CFG_PPS:      pps_cfg = int'(cfg_data[hfg_pkg::PPS_W-1:0]);
                    hfg_pkg::CFG_FOUR:     four_cfg = int'(cfg_data[0]);
                    default:               ;
                endcase
            end
            if (out_valid && !out_stall)
                check_result(out_item);
            if (in_valid && !in_stall)
                interpolate_item(in_item);
            fail_count <= err_cnt;
            pending <= predicted.size();
        end
    end

endmodule

[sim/tb.sv]
// Testbench top for the half-to-full grid interpolator: clock, reset, stimulus and verdict.
module tb;

    localparam int RUN_LIMIT = 400000;
    localparam logic [hfg_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic signed [hfg_pkg::VALUE_BITS-1:0] Q_MAX =
        {1'b0, {(hfg_pkg::VALUE_BITS-1){1'b1}}};
    localparam logic signed [hfg_pkg::VALUE_BITS-1:0] Q_MIN =
        {1'b1, {(hfg_pkg::VALUE_BITS-1){1'b0}}};
    localparam logic signed [hfg_pkg::VALUE_BITS-1:0] Q_ONE = 32'sh0001_0000;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    hfg_pkg::in_item_t in_item;
    logic out_valid;
    logic out_stall;
    hfg_pkg::out_item_t out_item;
    logic cfg_we;
    logic [hfg_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [hfg_pkg::CFG_DATA_W-1:0] cfg_data;
    int fail_count;
    int pending;

    int cycles = 0;
    int cur_ns = 5;
    int cur_pps = 1;
    int cur_four = 1;
    int burst_left = 0;
    int hold_asks = 0;
    bit written [hfg_pkg::GRID_DEPTH];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    half_to_full_grid_lagrange_interp i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hfg_checker i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: stall in segments of varying density, plus long hold-offs on request.
    initial
    begin : result_sink
        int seg_left;
        int stall_pct;
        int holds_done;
        seg_left = 0;
        stall_pct = 0;
        holds_done = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_asks)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(8, 64);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        2:       stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                seg_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic logic signed [hfg_pkg::VALUE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0, 1:    return Q_MAX;
            2, 3:    return Q_MIN;
            4, 5, 6: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic hfg_pkg::in_item_t make_item(input hfg_pkg::func_t f, input int s,
                                                    input int p,
                                                    input logic signed [31:0] v);
        hfg_pkg::in_item_t it;
        it.func = f;
        it.surface = s[hfg_pkg::SURF_W-1:0];
        it.point = p[hfg_pkg::POINT_W-1:0];
        it.sample = v;
        return it;
    endfunction

    function automatic bit setting_usable();
        int width;
        width = cur_four ? 4 : 2;
        if (cur_ns < 3 || cur_ns > hfg_pkg::NS_MAX) return 1'b0;
        if (cur_pps < 1 || cur_pps > hfg_pkg::POINTS_MAX) return 1'b0;
        return (cur_ns - 1 >= width);
    endfunction

    function automatic hfg_pkg::in_item_t random_item();
        int r;
        int s;
        int p;
        r = $urandom_range(0, 99);
        if (!setting_usable() || (r >= 30 && r < 40))
        begin
            p = $urandom_range(0, 1) ? $urandom_range(0, 1023) : cur_pps;
            return make_item(hfg_pkg::func_t'($urandom_range(0, 1)), $urandom_range(0, 63),
                             p, rand_sample());
        end
        if (r < 30)
            return make_item(hfg_pkg::FUNC_LOAD, $urandom_range(0, cur_ns - 2),
                             $urandom_range(0, cur_pps - 1), rand_sample());
        s = $urandom_range(0, cur_ns - 1);
        // Mostly reuse a few points so that stored data gets read many times.
        if ($urandom_range(0, 9) < 7)
            p = $urandom_range(0, (cur_pps < 8 ? cur_pps : 8) - 1);
        else
            p = $urandom_range(0, cur_pps - 1);
        return make_item(hfg_pkg::FUNC_COMPUTE, s, p, $urandom);
    endfunction

    task automatic issue(input hfg_pkg::in_item_t it);
        int gap;
        int r;
        if (burst_left == 0)
        begin
            r = $urandom_range(0, 99);
            gap = (r < 40) ? 0 : (r < 85) ? $urandom_range(1, 3) : $urandom_range(4, 15);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // A compute may only read stored entries, so fill any hole in its stencil first.
    task automatic load_missing(input int s, input int p);
        int width;
        int start;
        int idx;
        width = cur_four ? 4 : 2;
        start = s - width / 2;
        if (start < 0)
            start = 0;
        if (start > cur_ns - 1 - width)
            start = cur_ns - 1 - width;
        for (int k = 0; k < width; k++)
        begin
            idx = (start + k) * cur_pps + p;
            if (!written[idx])
            begin
                written[idx] = 1'b1;
                issue(make_item(hfg_pkg::FUNC_LOAD, start + k, p, rand_sample()));
            end
        end
    endtask

    task automatic send_any(input hfg_pkg::in_item_t it);
        int s;
        int p;
        s = int'(it.surface);
        p = int'(it.point);
        if (setting_usable())
        begin
            if (it.func == hfg_pkg::FUNC_LOAD)
            begin
                if (s < cur_ns - 1 && p < cur_pps)
                    written[s * cur_pps + p] = 1'b1;
            end else if (s < cur_ns && p < cur_pps)
            begin
                load_missing(s, p);
            end
        end
        issue(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    // Upper data bits beyond the surface-count and stencil-select registers' widths are filled with junk on purpose.
    task automatic set_config(input int ns, input int pps, input int four);
        drain();
        repeat (2) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= hfg_pkg::CFG_NUM_SURF;
        cfg_data <= hfg_pkg::CFG_DATA_W'(($urandom_range(0, 15) << 7) | (ns & 127));
        @(posedge clk);
        cfg_index <= hfg_pkg::CFG_PPS;
        cfg_data <= hfg_pkg::CFG_DATA_W'(pps);
        @(posedge clk);
        cfg_index <= hfg_pkg::CFG_FOUR;
        cfg_data <= hfg_pkg::CFG_DATA_W'(($urandom_range(0, 1023) << 1) | (four & 1));
        @(posedge clk);
        if ($urandom_range(0, 1))
        begin
            cfg_index <= CFG_SPARE;
            cfg_data <= hfg_pkg::CFG_DATA_W'($urandom_range(0, 2047));
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_ns = ns & 127;
        cur_pps = pps & 2047;
        cur_four = four & 1;
    endtask

    task automatic run_phase(input int n_items, input int pause_at);
        for (int i = 0; i < n_items; i++)
        begin
            if (i == pause_at)
                drain();
            send_any(random_item());
        end
    endtask

    initial
    begin : stimulus
        int ns;
        int four;
        int pps;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = hfg_pkg::CFG_NUM_SURF;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: five surfaces, one point, four-point stencil.
        send_any(make_item(hfg_pkg::FUNC_LOAD, 0, 0, Q_MAX));
        send_any(make_item(hfg_pkg::FUNC_LOAD, 1, 0, Q_MIN));
        send_any(make_item(hfg_pkg::FUNC_LOAD, 2, 0, Q_MAX));
        send_any(make_item(hfg_pkg::FUNC_LOAD, 3, 0, Q_MIN));
        for (int s = 0; s < 5; s++)
            send_any(make_item(hfg_pkg::FUNC_COMPUTE, s, 0, '0));
        send_any(make_item(hfg_pkg::FUNC_LOAD, 4, 0, Q_ONE));
        send_any(make_item(hfg_pkg::FUNC_LOAD, 0, 1, Q_ONE));
        send_any(make_item(hfg_pkg::FUNC_LOAD, 63, 1023, Q_MIN));
        send_any(make_item(hfg_pkg::FUNC_COMPUTE, 5, 0, '0));
        send_any(make_item(hfg_pkg::FUNC_COMPUTE, 63, 0, Q_MAX));
        send_any(make_item(hfg_pkg::FUNC_COMPUTE, 0, 1023, '0));
        send_any(make_item(hfg_pkg::FUNC_LOAD, 0, 0, Q_ONE));
        send_any(make_item(hfg_pkg::FUNC_LOAD, 1, 0, -Q_ONE));
        send_any(make_item(hfg_pkg::FUNC_LOAD, 2, 0, 32'sd1));
        send_any(make_item(hfg_pkg::FUNC_LOAD, 3, 0, -32'sd7));
        send_any(make_item(hfg_pkg::FUNC_COMPUTE, 0, 0, '0));
        send_any(make_item(hfg_pkg::FUNC_COMPUTE, 2, 0, '0));
        send_any(make_item(hfg_pkg::FUNC_COMPUTE, 4, 0, '0));

        set_config(3, 4, 0);
        run_phase(60, 30);

        // Largest grid; the result side holds off while items keep coming.
        set_config(64, 1024, 1);
        run_phase(30, -1);
        hold_asks++;
        run_phase(70, 40);

        // Unusable settings: too few or too many surfaces, stencil wider than the grid, bad point counts.
        set_config(2, 5, 0);
        run_phase(20, -1);
        set_config(3, 5, 1);
        run_phase(20, -1);
        set_config(10, 0, 1);
        run_phase(15, -1);
        set_config(10, 1025, 0);
        run_phase(15, -1);
        set_config(127, 2047, 1);
        run_phase(15, -1);

        set_config(64, 1024, 0);
        run_phase(80, 30);

        repeat (7)
        begin
            ns = $urandom_range(3, 64);
            four = (ns >= 5) ? $urandom_range(0, 1) : 0;
            pps = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(1, 1024);
            set_config(ns, pps, four);
            run_phase(70, $urandom_range(10, 60));
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
